/* rtl/jse_pkg.sv */
package jse_pkg;

    localparam int MAX_DIM      = 8;
    localparam int DATA_WIDTH   = 32;
    localparam int SWEEP_LIMIT  = 100;
    localparam int IDX_W        = 3;
    localparam int ADDR_W       = 2 * IDX_W;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CX_W         = 37;
    localparam int CZ_W         = 34;
    localparam int ACC_W        = 38;
    localparam int CS_W         = 18;

    localparam logic signed [CZ_W-1:0] ANG_PI   = 34'sd843314857;
    localparam logic signed [CX_W-1:0] KINV_Q30 = 37'sd652032874;
    localparam logic signed [CS_W-1:0] ONE_Q16  = 18'sd65536;

    localparam logic [2:0] REQ_WR_MAT = 3'd0;
    localparam logic [2:0] REQ_WR_VEC = 3'd1;
    localparam logic [2:0] REQ_RUN    = 3'd2;
    localparam logic [2:0] REQ_RD_MAT = 3'd3;
    localparam logic [2:0] REQ_RD_VEC = 3'd4;

    localparam logic [1:0] CFG_DIM    = 2'd0;
    localparam logic [1:0] CFG_SWEEPS = 2'd1;
    localparam logic [1:0] CFG_TOL    = 2'd2;
    localparam logic [1:0] CFG_UPD    = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE, ST_READ, ST_SWEEP, ST_PAIR, ST_RD_KL, ST_CHK_KL, ST_GET_KK,
        ST_GET_LL, ST_ATAN, ST_SINCOS, ST_MUL_CC, ST_MUL_SS, ST_MUL_CS, ST_GET_CS,
        ST_KK1, ST_KK2, ST_KK3, ST_KK4, ST_LL2, ST_LL3, ST_LL4, ST_ZERO_KL,
        ST_ZERO_LK, ST_ROW, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_E7,
        ST_E8, ST_E9, ST_E10, ST_END_SWEEP, ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } t_mac_op;

    typedef struct packed {
        logic                    en;
        t_mac_op                 op;
        logic                    sh15;
        logic signed [31:0]      a;
        logic signed [CS_W-1:0]  b;
    } t_mac_req;

    typedef struct packed {
        logic                    start;
        logic                    vec;
        logic signed [CX_W-1:0]  x;
        logic signed [CX_W-1:0]  y;
        logic signed [CZ_W-1:0]  z;
    } t_cordic_req;

    function automatic logic signed [CZ_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [CZ_W-1:0] v;
        case (i)
            5'd0: v = 34'sd210828714;
            5'd1: v = 34'sd124459459;
            5'd2: v = 34'sd65760959;
            5'd3: v = 34'sd33381289;
            5'd4: v = 34'sd16755422;
            5'd5: v = 34'sd8385879;
            5'd6: v = 34'sd4193963;
            5'd7: v = 34'sd2097109;
            5'd8: v = 34'sd1048571;
            5'd9: v = 34'sd524287;
            default: v = CZ_W'(1) <<< (28 - int'(i));
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat_val(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [CS_W-1:0] clamp_one(input logic signed [ACC_W-1:0] v);
        logic signed [CS_W-1:0] r;
        if (v > 38'sd65536) begin
            r = ONE_Q16;
        end else if (v < -38'sd65536) begin
            r = -ONE_Q16;
        end else begin
            r = v[CS_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/jse_cordic.sv */
module jse_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jse_pkg::t_cordic_req                i_req,
    output logic                                o_done,
    output logic signed [jse_pkg::CX_W-1:0]     o_x,
    output logic signed [jse_pkg::CX_W-1:0]     o_y,
    output logic signed [jse_pkg::CZ_W-1:0]     o_z
);
    import jse_pkg::*;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [STEP_W-1:0]       r_step, n_step;
    logic                    r_vec, n_vec;
    logic signed [CX_W-1:0]  r_x, n_x, r_y, n_y, dx, dy;
    logic signed [CZ_W-1:0]  r_z, n_z, ang;
    logic                    plus;

    always_comb begin
        dx   = r_y >>> r_step;
        dy   = r_x >>> r_step;
        ang  = atan_step(r_step);
        plus = r_vec ? (r_y > 0) : (r_z < 0);
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_vec  = r_vec;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_vec  = i_req.vec;
            if (i_req.vec && i_req.x < 0) begin
                n_x = -i_req.x;
                n_y = -i_req.y;
                n_z = (i_req.y >= 0) ? ANG_PI : -ANG_PI;
            end else begin
                n_x = i_req.x;
                n_y = i_req.y;
                n_z = i_req.z;
            end
        end else if (r_busy) begin
            if (plus) begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + ang;
            end else begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - ang;
            end
            n_step = r_step + 5'd1;
            if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

/* rtl/jse_mac.sv */
module jse_mac (
    input  logic                                i_clk,
    input  jse_pkg::t_mac_req                   i_req,
    output logic signed [jse_pkg::ACC_W-1:0]    o_acc
);
    import jse_pkg::*;

    logic [31:0]             ma;
    logic [CS_W-1:0]         mb;
    logic [49:0]             prod;
    logic [50:0]             rsum;
    logic [35:0]             mag;
    logic                    neg;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] r_acc;

    always_comb begin
        ma   = i_req.a[31] ? (~i_req.a + 32'd1) : i_req.a;
        mb   = i_req.b[CS_W-1] ? (~i_req.b + 18'd1) : i_req.b;
        prod = 50'(ma) * 50'(mb);
        rsum = 51'(prod) + (i_req.sh15 ? (51'(1) << 14) : (51'(1) << 15));
        mag  = i_req.sh15 ? 36'(rsum >> 15) : 36'(rsum >> 16);
        neg  = i_req.a[31] ^ i_req.b[CS_W-1];
        term = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            case (i_req.op)
                MAC_LOAD: r_acc <= term;
                MAC_ADD:  r_acc <= r_acc + term;
                MAC_SUB:  r_acc <= r_acc - term;
                default:  r_acc <= r_acc;
            endcase
        end
    end

    assign o_acc = r_acc;

endmodule

/* rtl/jacobi_symmetric_eigen_decomposition.sv */
// Cyclic Jacobi eigen-decomposition of a symmetric matrix of up to 8 by 8 signed Q16.16
// entries, with an optional vector matrix rotated along. Every request item gives exactly
// one result item. No new request item is taken until the block is idle and the previous
// result has been or is being taken. A run rotates, in each sweep, every off-diagonal pair
// that is not already zero, and the vector matrix along with it when the vector update is
// on; the two passes of the shared CORDIC unit and the single read and write port of each
// store set the pace of a run.
// The stores need no clearing after reset, but every entry that a run or a read touches
// must have been written first.
module jacobi_symmetric_eigen_decomposition (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index, col_index, write_value, 2'b0 pad
    input  logic [2:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // read_value, converged, sweeps_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import jse_pkg::*;

    t_state                  r_state, n_state;
    logic [3:0]              r_k, n_k, r_l, n_l, r_i, n_i;
    logic                    r_vec, n_vec;
    logic [31:0]             r_maxdev, n_maxdev;
    logic signed [31:0]      r_akl, n_akl, r_akk, n_akk, r_all, n_all;
    logic signed [31:0]      r_ek, n_ek, r_el, n_el, r_nk, n_nk, r_nl, n_nl;
    logic signed [CS_W-1:0]  r_c, n_c, r_s, n_s, r_cc, n_cc, r_ss, n_ss, r_cs2, n_cs2;
    logic                    r_conv, n_conv;
    logic [6:0]              r_sweeps, n_sweeps;
    logic [3:0]              r_dim;
    logic [6:0]              r_maxsw;
    logic [15:0]             r_tol;
    logic                    r_upd;
    logic                    r_out_valid;
    logic [39:0]             r_out_data;

    logic signed [31:0]      mem_m [MAX_DIM*MAX_DIM];
    logic signed [31:0]      mem_v [MAX_DIM*MAX_DIM];
    logic signed [31:0]      r_m_rd, r_v_rd, rd_sel;
    logic                    we_m, we_v;
    logic [ADDR_W-1:0]       waddr, raddr;
    logic signed [31:0]      wdata;

    t_mac_req                mac_req;
    logic signed [ACC_W-1:0] acc;
    logic signed [31:0]      acc_sat;
    t_cordic_req             cord_req;
    logic                    cord_done;
    logic signed [CX_W-1:0]  cord_x;
    logic signed [CX_W-1:0]  cord_y;
    logic signed [CZ_W-1:0]  cord_z;
    logic signed [CS_W-1:0]  cord_c;
    logic signed [CS_W-1:0]  cord_s;

    logic                    in_acc, out_load;
    logic [39:0]             out_data;
    logic [2:0]              req;
    logic [IDX_W-1:0]        in_row, in_col;
    logic signed [31:0]      in_val;
    logic [3:0]              dim_n;
    logic [6:0]              lim;
    logic [31:0]             mag;
    logic [IDX_W-1:0]        k3, l3, i3;

    jse_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cord_req),
        .o_done  (cord_done),
        .o_x     (cord_x),
        .o_y     (cord_y),
        .o_z     (cord_z)
    );

    jse_mac u_mac (
        .i_clk (i_clk),
        .i_req (mac_req),
        .o_acc (acc)
    );

    assign req    = s_axis_tuser;
    assign in_row = s_axis_tdata[2:0];
    assign in_col = s_axis_tdata[5:3];
    assign in_val = s_axis_tdata[37:6];
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;

    assign dim_n   = (r_dim > 4'(MAX_DIM)) ? 4'(MAX_DIM) : r_dim;
    assign lim     = (r_maxsw > 7'(SWEEP_LIMIT)) ? 7'(SWEEP_LIMIT) : r_maxsw;
    assign rd_sel  = r_vec ? r_v_rd : r_m_rd;
    assign acc_sat = sat_val(acc);
    assign mag     = r_m_rd[31] ? (~r_m_rd + 32'd1) : r_m_rd;
    assign cord_c  = clamp_one(ACC_W'((cord_x + CX_W'(8192)) >>> 14));
    assign cord_s  = clamp_one(ACC_W'((cord_y + CX_W'(8192)) >>> 14));
    assign k3      = r_k[IDX_W-1:0];
    assign l3      = r_l[IDX_W-1:0];
    assign i3      = r_i[IDX_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_k = r_k;
        n_l = r_l;
        n_i = r_i;
        n_vec    = r_vec;
        n_maxdev = r_maxdev;
        n_akl = r_akl;
        n_akk = r_akk;
        n_all = r_all;
        n_ek  = r_ek;
        n_el  = r_el;
        n_nk  = r_nk;
        n_nl  = r_nl;
        n_c   = r_c;
        n_s   = r_s;
        n_cc  = r_cc;
        n_ss  = r_ss;
        n_cs2 = r_cs2;
        n_conv   = r_conv;
        n_sweeps = r_sweeps;
        we_m  = 1'b0;
        we_v  = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        mac_req  = '0;
        cord_req = '0;
        out_load = 1'b0;
        out_data = {r_sweeps, r_conv, 32'd0};

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (req)
                        REQ_WR_MAT: begin
                            we_m  = 1'b1;
                            waddr = {in_row, in_col};
                            wdata = in_val;
                            out_load = 1'b1;
                        end
                        REQ_WR_VEC: begin
                            we_v  = 1'b1;
                            waddr = {in_row, in_col};
                            wdata = in_val;
                            out_load = 1'b1;
                        end
                        REQ_RUN: begin
                            n_conv   = 1'b0;
                            n_sweeps = '0;
                            n_state  = (lim == 7'd0) ? ST_FINISH : ST_SWEEP;
                        end
                        REQ_RD_MAT, REQ_RD_VEC: begin
                            raddr   = {in_row, in_col};
                            n_vec   = (req == REQ_RD_VEC);
                            n_state = ST_READ;
                        end
                        default: out_load = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                out_load = 1'b1;
                out_data = {r_sweeps, r_conv, rd_sel};
                n_state  = ST_IDLE;
            end
            ST_SWEEP: begin
                n_sweeps = r_sweeps + 7'd1;
                n_maxdev = '0;
                n_k = 4'd0;
                n_l = 4'd1;
                n_state = ST_PAIR;
            end
            ST_PAIR: begin
                if (r_l < dim_n) begin
                    n_state = ST_RD_KL;
                end else begin
                    n_k = r_k + 4'd1;
                    n_l = r_k + 4'd2;
                    if (r_k + 4'd1 >= dim_n) begin
                        n_state = ST_END_SWEEP;
                    end
                end
            end
            ST_RD_KL: begin
                raddr   = {k3, l3};
                n_state = ST_CHK_KL;
            end
            ST_CHK_KL: begin
                if (r_m_rd == 32'sd0) begin
                    n_l = r_l + 4'd1;
                    n_state = ST_PAIR;
                end else begin
                    n_akl = r_m_rd;
                    if (mag > r_maxdev) begin
                        n_maxdev = mag;
                    end
                    raddr   = {k3, k3};
                    n_state = ST_GET_KK;
                end
            end
            ST_GET_KK: begin
                n_akk   = r_m_rd;
                raddr   = {l3, l3};
                n_state = ST_GET_LL;
            end
            ST_GET_LL: begin
                n_all = r_m_rd;
                cord_req.start = 1'b1;
                cord_req.vec   = 1'b1;
                cord_req.x     = CX_W'(r_akk) - CX_W'(r_m_rd);
                cord_req.y     = CX_W'(r_akl) <<< 1;
                n_state = ST_ATAN;
            end
            ST_ATAN: begin
                if (cord_done) begin
                    cord_req.start = 1'b1;
                    cord_req.x     = KINV_Q30;
                    cord_req.z     = cord_z >>> 1;
                    n_state = ST_SINCOS;
                end
            end
            ST_SINCOS: begin
                if (cord_done) begin
                    n_c = cord_c;
                    n_s = cord_s;
                    n_state = ST_MUL_CC;
                end
            end
            ST_MUL_CC: begin
                mac_req = '{en: 1'b1, op: MAC_LOAD, sh15: 1'b0, a: 32'(r_c), b: r_c};
                n_state = ST_MUL_SS;
            end
            ST_MUL_SS: begin
                n_cc = acc[CS_W-1:0];
                mac_req = '{en: 1'b1, op: MAC_LOAD, sh15: 1'b0, a: 32'(r_s), b: r_s};
                n_state = ST_MUL_CS;
            end
            ST_MUL_CS: begin
                n_ss = acc[CS_W-1:0];
                mac_req = '{en: 1'b1, op: MAC_LOAD, sh15: 1'b1, a: 32'(r_c), b: r_s};
                n_state = ST_GET_CS;
            end
            ST_GET_CS: begin
                n_cs2   = clamp_one(acc);
                n_state = ST_KK1;
            end
            ST_KK1: begin
                mac_req = '{en: 1'b1, op: MAC_LOAD, sh15: 1'b0, a: r_akk, b: r_cc};
                n_state = ST_KK2;
            end
            ST_KK2: begin
                mac_req = '{en: 1'b1, op: MAC_ADD, sh15: 1'b0, a: r_all, b: r_ss};
                n_state = ST_KK3;
            end
            ST_KK3: begin
                mac_req = '{en: 1'b1, op: MAC_ADD, sh15: 1'b0, a: r_akl, b: r_cs2};
                n_state = ST_KK4;
            end
            ST_KK4: begin
                we_m  = 1'b1;
                waddr = {k3, k3};
                wdata = acc_sat;
                mac_req = '{en: 1'b1, op: MAC_LOAD, sh15: 1'b0, a: r_all, b: r_cc};
                n_state = ST_LL2;
            end
            ST_LL2: begin
                mac_req = '{en: 1'b1, op: MAC_ADD, sh15: 1'b0, a: r_akk, b: r_ss};
                n_state = ST_LL3;
            end
            ST_LL3: begin
                mac_req = '{en: 1'b1, op: MAC_SUB, sh15: 1'b0, a: r_akl, b: r_cs2};
                n_state = ST_LL4;
            end
            ST_LL4: begin
                we_m  = 1'b1;
                waddr = {l3, l3};
                wdata = acc_sat;
                n_state = ST_ZERO_KL;
            end
            ST_ZERO_KL: begin
                we_m  = 1'b1;
                waddr = {k3, l3};
                n_state = ST_ZERO_LK;
            end
            ST_ZERO_LK: begin
                we_m  = 1'b1;
                waddr = {l3, k3};
                n_i   = 4'd0;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                if (r_i >= dim_n) begin
                    n_l = r_l + 4'd1;
                    n_state = ST_PAIR;
                end else if (r_i != r_k && r_i != r_l) begin
                    n_vec   = 1'b0;
                    n_state = ST_E1;
                end else if (r_upd) begin
                    n_vec   = 1'b1;
                    n_state = ST_E1;
                end else begin
                    n_i = r_i + 4'd1;
                end
            end
            ST_E1: begin
                raddr   = {k3, i3};
                n_state = ST_E2;
            end
            ST_E2: begin
                n_ek    = rd_sel;
                raddr   = {l3, i3};
                n_state = ST_E3;
            end
            ST_E3: begin
                n_el    = rd_sel;
                mac_req = '{en: 1'b1, op: MAC_LOAD, sh15: 1'b0, a: r_ek, b: r_c};
                n_state = ST_E4;
            end
            ST_E4: begin
                mac_req = '{en: 1'b1, op: MAC_ADD, sh15: 1'b0, a: r_el, b: r_s};
                n_state = ST_E5;
            end
            ST_E5: begin
                n_nk    = acc_sat;
                mac_req = '{en: 1'b1, op: MAC_LOAD, sh15: 1'b0, a: r_el, b: r_c};
                n_state = ST_E6;
            end
            ST_E6: begin
                mac_req = '{en: 1'b1, op: MAC_SUB, sh15: 1'b0, a: r_ek, b: r_s};
                n_state = ST_E7;
            end
            ST_E7: begin
                we_m  = !r_vec;
                we_v  = r_vec;
                waddr = {k3, i3};
                wdata = r_nk;
                n_nl  = acc_sat;
                n_state = ST_E8;
            end
            ST_E8: begin
                we_m  = !r_vec;
                we_v  = r_vec;
                waddr = {l3, i3};
                wdata = r_nl;
                if (r_vec) begin
                    n_i = r_i + 4'd1;
                    n_state = ST_ROW;
                end else begin
                    n_state = ST_E9;
                end
            end
            ST_E9: begin
                we_m  = 1'b1;
                waddr = {i3, k3};
                wdata = r_nk;
                n_state = ST_E10;
            end
            ST_E10: begin
                we_m  = 1'b1;
                waddr = {i3, l3};
                wdata = r_nl;
                if (r_upd) begin
                    n_vec   = 1'b1;
                    n_state = ST_E1;
                end else begin
                    n_i = r_i + 4'd1;
                    n_state = ST_ROW;
                end
            end
            ST_END_SWEEP: begin
                if (r_maxdev <= {16'd0, r_tol}) begin
                    n_conv  = 1'b1;
                    n_state = ST_FINISH;
                end else if (r_sweeps >= lim) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SWEEP;
                end
            end
            ST_FINISH: begin
                out_load = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_conv      <= 1'b0;
            r_sweeps    <= '0;
            r_dim       <= 4'd8;
            r_maxsw     <= 7'd100;
            r_tol       <= '0;
            r_upd       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_conv   <= n_conv;
            r_sweeps <= n_sweeps;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DIM:    r_dim   <= i_cfg_data[3:0];
                    CFG_SWEEPS: r_maxsw <= i_cfg_data[6:0];
                    CFG_TOL:    r_tol   <= i_cfg_data;
                    CFG_UPD:    r_upd   <= i_cfg_data[0];
                    default:    r_upd   <= r_upd;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_l <= n_l;
        r_i <= n_i;
        r_vec    <= n_vec;
        r_maxdev <= n_maxdev;
        r_akl <= n_akl;
        r_akk <= n_akk;
        r_all <= n_all;
        r_ek  <= n_ek;
        r_el  <= n_el;
        r_nk  <= n_nk;
        r_nl  <= n_nl;
        r_c   <= n_c;
        r_s   <= n_s;
        r_cc  <= n_cc;
        r_ss  <= n_ss;
        r_cs2 <= n_cs2;
        if (out_load) begin
            r_out_data <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_m) begin
            mem_m[waddr] <= wdata;
        end
        r_m_rd <= mem_m[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_v) begin
            mem_v[waddr] <= wdata;
        end
        r_v_rd <= mem_v[raddr];
    end

endmodule

/* rtl/jse_checker.sv */
module jse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    import jse_pkg::*;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input taken while an unread result would be lost");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser == REQ_WR_MAT || s_axis_tuser == REQ_WR_VEC)
        |=> m_axis_tvalid && m_axis_tdata[31:0] == 32'd0)
        else $error("write item did not give a zero result in the next cycle");

    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[39:33] != 7'd0)
        else $error("converged reported with no sweep done");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind jacobi_symmetric_eigen_decomposition jse_checker u_jse_checker (.*);
